// File: rtl/lrf_pkg.sv
// Shared types and constants for the least-squares line fit block.
`timescale 1ns / 1ps
package lrf_pkg;

  localparam int MAX_POINTS_DEF = 128;
  localparam int SAMPLE_W       = 16;
  localparam int FRAC_W         = 16;
  localparam int FIT_W          = 48;
  localparam int R2_W           = 17;
  localparam int COUNT_OUT_W    = 8;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 128;

  // operations of the shared shift/add unit
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SUB
  } lrf_op_t;

  typedef struct packed {
    logic    start;
    lrf_op_t op;
  } lrf_cmd_t;

  typedef struct packed {
    logic done;
    logic neg;   // borrow of the last subtract
    logic ovf;   // quotient bits shifted out above the kept range
  } lrf_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SXX_A,
    ST_SXX_B,
    ST_SXX,
    ST_SYY_A,
    ST_SYY_B,
    ST_SYY,
    ST_SXY_A,
    ST_SXY_B,
    ST_SXY,
    ST_SXY_NEG,
    ST_SLOPE,
    ST_INT_A,
    ST_INT_B,
    ST_INT,
    ST_INT_NEG,
    ST_INT_DIV,
    ST_R2_A,
    ST_R2_B,
    ST_R2_DIV,
    ST_FINISH
  } lrf_state_t;

endpackage

// File: rtl/linear_regression_fit.sv
// Top level of the streaming least-squares line fit.
`timescale 1ns / 1ps
// Points stream in on s_axis at one transfer per cycle while idle, and are folded into
// exact running sums (n, sum x, sum y, sum xx, sum yy, sum xy); points past MAX_POINTS
// are dropped and flagged. The point with tlast closes the set: the block then
// drops s_axis_tready and works out slope, intercept and r squared on a single
// bit-serial shift/add/subtract unit, one bit per cycle. That takes ten HW-bit
// multiplies, up to six subtracts and three NW-bit divides, where
// HW = clog2(MAX_POINTS+1) + clog2(MAX_POINTS*65535+1) + 16 and NW = 2*HW + 16
// (a degenerate set stops after the variances and the covariance). The result sits
// in an output register until taken on m_axis; the sums clear when it is loaded,
// and the next set may stream in while it waits.
module linear_regression_fit import lrf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // x_value[15:0], y_value[31:16]
  input  logic                  s_axis_tlast,   // last_point
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // slope[47:0], intercept[95:48], r_squared[112:96], degenerate[113],
  // overflowed[114], point_count[122:115], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = $clog2(MAX_POINTS * 65535 + 1);
  localparam int QW = SW + SAMPLE_W;
  localparam int HW = CW + QW;
  localparam int PW = 2 * HW;
  localparam int AW = PW + 1;
  localparam int NW = PW + FRAC_W;

  localparam logic [FIT_W-1:0] POS_CAP = {1'b0, {(FIT_W-1){1'b1}}};
  localparam logic [FIT_W-1:0] NEG_CAP = {1'b1, {(FIT_W-1){1'b0}}};
  localparam logic [FIT_W-1:0] R2_ONE  = FIT_W'(1) << FRAC_W;

  lrf_state_t state, state_next;
  lrf_cmd_t   cmd;
  lrf_stat_t  stat;
  logic       issued;

  logic [CW-1:0] count;
  logic [SW-1:0] sum_x, sum_y;
  logic [QW-1:0] sum_xx, sum_yy, sum_xy;
  logic          dropped;

  logic [SAMPLE_W-1:0]   x_in, y_in;
  logic [2*SAMPLE_W-1:0] xx, yy, xy;
  logic                  in_xfer;

  logic [PW-1:0] pa, pb;
  logic [HW-1:0] sxx, syy, sxy;
  logic          sxy_neg, int_neg;
  logic          degen;
  logic [FIT_W-1:0] res_slope, res_icpt;
  logic [R2_W-1:0]  res_r2;

  logic [HW-1:0] mx, my;
  logic [PW-1:0] dn, dd, sa, sb;
  logic [NW-1:0] op_a;
  logic [AW-1:0] op_b;
  logic [AW-1:0] acc;
  logic [FIT_W-1:0] quo;
  logic          out_free;

  logic [FIT_W-1:0]       slope, intercept;
  logic [R2_W-1:0]        r_squared;
  logic                   degenerate, overflowed;
  logic [COUNT_OUT_W-1:0] point_count;

  function automatic logic [FIT_W-1:0] sat_fit(input logic neg, input logic ovf,
                                               input logic [FIT_W-1:0] q);
    logic [FIT_W-1:0] cap;
    logic [FIT_W-1:0] mag;
    cap = neg ? NEG_CAP : POS_CAP;
    mag = (ovf || q > cap) ? cap : q;
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  assign x_in    = s_axis_tdata[SAMPLE_W-1:0];
  assign y_in    = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign xx      = 32'(x_in) * 32'(x_in);
  assign yy      = 32'(y_in) * 32'(y_in);
  assign xy      = 32'(x_in) * 32'(y_in);
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign degen   = (sxx == '0) || (syy == '0);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  lrf_alu #(.MAX_POINTS(MAX_POINTS)) u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .op_a (op_a),
    .op_b (op_b),
    .stat (stat),
    .acc  (acc),
    .quo  (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        issued <= 1'b1;
      end else if (stat.done) begin
        issued <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_MUL;
    mx = '0;
    my = '0;
    dn = '0;
    dd = '0;
    sa = pa;
    sb = pb;
    case (state)
      ST_IDLE: begin
        if (in_xfer && s_axis_tlast) begin
          state_next = ST_SXX_A;
        end
      end
      ST_SXX_A: begin
        mx = HW'(count);
        my = HW'(sum_xx);
        if (stat.done) state_next = ST_SXX_B;
      end
      ST_SXX_B: begin
        mx = HW'(sum_x);
        my = HW'(sum_x);
        if (stat.done) state_next = ST_SXX;
      end
      ST_SXX: begin
        cmd.op = OP_SUB;
        if (stat.done) state_next = ST_SYY_A;
      end
      ST_SYY_A: begin
        mx = HW'(count);
        my = HW'(sum_yy);
        if (stat.done) state_next = ST_SYY_B;
      end
      ST_SYY_B: begin
        mx = HW'(sum_y);
        my = HW'(sum_y);
        if (stat.done) state_next = ST_SYY;
      end
      ST_SYY: begin
        cmd.op = OP_SUB;
        if (stat.done) state_next = ST_SXY_A;
      end
      ST_SXY_A: begin
        mx = HW'(count);
        my = HW'(sum_xy);
        if (stat.done) state_next = ST_SXY_B;
      end
      ST_SXY_B: begin
        mx = HW'(sum_x);
        my = HW'(sum_y);
        if (stat.done) state_next = ST_SXY;
      end
      ST_SXY: begin
        cmd.op = OP_SUB;
        if (stat.done) begin
          if (stat.neg) state_next = ST_SXY_NEG;
          else          state_next = degen ? ST_FINISH : ST_SLOPE;
        end
      end
      ST_SXY_NEG: begin
        cmd.op = OP_SUB;
        sa = pb;
        sb = pa;
        if (stat.done) state_next = degen ? ST_FINISH : ST_SLOPE;
      end
      ST_SLOPE: begin
        cmd.op = OP_DIV;
        dn = PW'(sxy);
        dd = PW'(sxx);
        if (stat.done) state_next = ST_INT_A;
      end
      ST_INT_A: begin
        mx = HW'(sum_y);
        my = HW'(sum_xx);
        if (stat.done) state_next = ST_INT_B;
      end
      ST_INT_B: begin
        mx = HW'(sum_x);
        my = HW'(sum_xy);
        if (stat.done) state_next = ST_INT;
      end
      ST_INT: begin
        cmd.op = OP_SUB;
        if (stat.done) state_next = stat.neg ? ST_INT_NEG : ST_INT_DIV;
      end
      ST_INT_NEG: begin
        cmd.op = OP_SUB;
        sa = pb;
        sb = pa;
        if (stat.done) state_next = ST_INT_DIV;
      end
      ST_INT_DIV: begin
        cmd.op = OP_DIV;
        dn = pa;
        dd = PW'(sxx);
        if (stat.done) state_next = ST_R2_A;
      end
      ST_R2_A: begin
        mx = sxy;
        my = sxy;
        if (stat.done) state_next = ST_R2_B;
      end
      ST_R2_B: begin
        mx = sxx;
        my = syy;
        if (stat.done) state_next = ST_R2_DIV;
      end
      ST_R2_DIV: begin
        cmd.op = OP_DIV;
        dn = pa;
        dd = pb;
        if (stat.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    cmd.start = (state != ST_IDLE) && (state != ST_FINISH) && !issued && !stat.done;

    case (cmd.op)
      OP_MUL: begin
        op_a = NW'(mx) << (NW - HW);
        op_b = AW'(my);
      end
      OP_DIV: begin
        op_a = NW'(dn) << FRAC_W;
        op_b = AW'(dd);
      end
      default: begin
        op_a = NW'(sa);
        op_b = AW'(sb);
      end
    endcase
  end

  // running sums
  always_ff @(posedge clk) begin
    if (rst || (state == ST_FINISH && out_free)) begin
      count   <= '0;
      sum_x   <= '0;
      sum_y   <= '0;
      sum_xx  <= '0;
      sum_yy  <= '0;
      sum_xy  <= '0;
      dropped <= 1'b0;
    end else if (in_xfer) begin
      if (count < CW'(MAX_POINTS)) begin
        count  <= count + 1'b1;
        sum_x  <= sum_x + SW'(x_in);
        sum_y  <= sum_y + SW'(y_in);
        sum_xx <= sum_xx + QW'(xx);
        sum_yy <= sum_yy + QW'(yy);
        sum_xy <= sum_xy + QW'(xy);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // capture unit results
  always_ff @(posedge clk) begin
    if (stat.done) begin
      case (state)
        ST_SXX_A, ST_SYY_A, ST_SXY_A, ST_INT_A, ST_R2_A: pa <= acc[PW-1:0];
        ST_SXX_B, ST_SYY_B, ST_SXY_B, ST_INT_B, ST_R2_B: pb <= acc[PW-1:0];
        ST_SXX: sxx <= acc[HW-1:0];
        ST_SYY: syy <= acc[HW-1:0];
        ST_SXY: begin
          sxy     <= acc[HW-1:0];
          sxy_neg <= 1'b0;
        end
        ST_SXY_NEG: begin
          sxy     <= acc[HW-1:0];
          sxy_neg <= 1'b1;
        end
        ST_INT: begin
          // on a borrow pa must survive for the swapped subtract
          if (!stat.neg) begin
            pa      <= acc[PW-1:0];
            int_neg <= 1'b0;
          end
        end
        ST_INT_NEG: begin
          pa      <= acc[PW-1:0];
          int_neg <= 1'b1;
        end
        ST_SLOPE:   res_slope <= sat_fit(sxy_neg, stat.ovf, quo);
        ST_INT_DIV: res_icpt  <= sat_fit(int_neg, stat.ovf, quo);
        ST_R2_DIV:  res_r2    <= (stat.ovf || quo > R2_ONE) ? R2_ONE[R2_W-1:0] : quo[R2_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      slope       <= degen ? '0 : res_slope;
      intercept   <= degen ? '0 : res_icpt;
      r_squared   <= degen ? '0 : res_r2;
      degenerate  <= degen;
      overflowed  <= dropped;
      point_count <= COUNT_OUT_W'(count);
    end
  end

  assign m_axis_tdata = {
    (OUT_DATA_W - 2*FIT_W - R2_W - 2 - COUNT_OUT_W)'(0),
    point_count, overflowed, degenerate, r_squared, intercept, slope
  };

endmodule

// File: rtl/lrf_alu.sv
// Shared bit-serial unit: shift-add multiply, restoring divide and one-step subtract.
`timescale 1ns / 1ps
module lrf_alu import lrf_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int CW  = $clog2(MAX_POINTS + 1),
  localparam int SW  = $clog2(MAX_POINTS * 65535 + 1),
  localparam int QW  = SW + SAMPLE_W,
  localparam int HW  = CW + QW,
  localparam int PW  = 2 * HW,
  localparam int AW  = PW + 1,
  localparam int NW  = PW + FRAC_W,
  localparam int STW = $clog2(NW + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  lrf_cmd_t          cmd,
  input  logic [NW-1:0]     op_a,   // multiplier (left aligned), dividend or minuend
  input  logic [AW-1:0]     op_b,   // multiplicand, divisor or subtrahend
  output lrf_stat_t         stat,
  output logic [AW-1:0]     acc,
  output logic [FIT_W-1:0]  quo
);

  lrf_op_t        op;
  logic           busy;
  logic [STW-1:0] cnt;
  logic [NW-1:0]  shreg;
  logic           msb;
  logic [AW-1:0]  t;
  logic [AW-1:0]  x;
  logic [AW-1:0]  y;
  logic [AW:0]    res;
  logic           done;
  logic           neg;
  logic           ovf;

  assign stat = '{done: done, neg: neg, ovf: ovf};

  assign msb = shreg[NW-1];
  assign t   = {acc[AW-2:0], (op == OP_DIV) & msb};
  assign x   = (op == OP_SUB) ? acc : t;
  assign y   = (op == OP_MUL && !msb) ? '0 : op_b;
  assign res = (op == OP_MUL) ? ({1'b0, x} + {1'b0, y}) : ({1'b0, x} - {1'b0, y});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        case (cmd.op)
          OP_MUL:  cnt <= STW'(HW);
          OP_DIV:  cnt <= STW'(NW);
          default: cnt <= STW'(1);
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      shreg <= op_a;
      acc   <= (cmd.op == OP_SUB) ? op_a[AW-1:0] : '0;
      quo   <= '0;
      ovf   <= 1'b0;
      neg   <= 1'b0;
    end else if (busy) begin
      shreg <= {shreg[NW-2:0], 1'b0};
      case (op)
        OP_MUL: begin
          acc <= res[AW-1:0];
        end
        OP_DIV: begin
          // keep the partial remainder when the trial subtract borrows
          acc <= res[AW] ? x : res[AW-1:0];
          quo <= {quo[FIT_W-2:0], !res[AW]};
          ovf <= ovf | quo[FIT_W-1];
        end
        default: begin
          acc <= res[AW-1:0];
          neg <= res[AW];
        end
      endcase
    end
  end

endmodule

// File: rtl/lrf_checker.sv
// Port-level checks for the line fit block, bound to the top level.
`timescale 1ns / 1ps
module lrf_checker import lrf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // closing point starts the fit, input side goes busy
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after closing point");

  // degenerate set carries zero slope, intercept and r squared
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[113] |-> m_axis_tdata[112:0] == '0)
    else $error("degenerate result with nonzero fit");

  // r squared never above one
  a_r2_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[112] |-> m_axis_tdata[111:96] == '0)
    else $error("r squared above one");

endmodule

bind linear_regression_fit lrf_checker u_lrf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
